/* hw/rtl/psrb_pkg.sv */
// psrb_pkg: shared types, request codes and pointer helpers for the paired
// sensor ring buffer; no dependencies
package psrb_pkg;

  localparam int DEPTH      = 16;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int FILL_BITS  = 5;
  localparam int STAMP_BITS = 32;
  localparam int DATA_BITS  = 32;

  // request codes
  localparam logic [1:0] REQ_PUSH_RADAR = 2'd0;
  localparam logic [1:0] REQ_PUSH_CAM   = 2'd1;
  localparam logic [1:0] REQ_POP        = 2'd2;
  localparam logic [1:0] REQ_NOP        = 2'd3;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [STAMP_BITS-1:0] stamp;
    logic [DATA_BITS-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic                  empty_error;
    logic [STAMP_BITS-1:0] radar_stamp;
    logic [DATA_BITS-1:0]  radar_data;
    logic [STAMP_BITS-1:0] cam_stamp;
    logic [DATA_BITS-1:0]  cam_data;
    logic                  in_sync;
    logic [FILL_BITS-1:0]  radar_fill;
    logic [FILL_BITS-1:0]  cam_fill;
  } rsp_t;

  // ring pointer step forward with wrap
  function automatic logic [ADDR_BITS-1:0] ptr_next(input logic [ADDR_BITS-1:0] p);
    ptr_next = (p == ADDR_BITS'(DEPTH - 1)) ? '0 : p + ADDR_BITS'(1);
  endfunction

  // ring pointer step back with wrap
  function automatic logic [ADDR_BITS-1:0] ptr_prev(input logic [ADDR_BITS-1:0] p);
    ptr_prev = (p == '0) ? ADDR_BITS'(DEPTH - 1) : p - ADDR_BITS'(1);
  endfunction

endpackage

/* hw/rtl/paired_sensor_ring_buffer_unit.sv */
// paired_sensor_ring_buffer_unit: top level with two sample rams, pointers,
// counts and the request sequencer; depends on psrb_pkg, psrb_ram, psrb_sync
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one request word, push radar,
//   push camera, pop newest pair, or a no-op code.
//   out channel (out_valid/out_ready/out_data): exactly one result word per
//   request, in request order, held in an output register.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes max_drift, always ready;
//   write it only while no request is in flight.
// Result timing and throughput:
//   push, refused pop and no-op: result in the cycle after acceptance, so one
//   request per cycle while the receiver keeps taking words.
//   pop: result via S_POP1, S_POP2 and the output register; each ram has one
//   read port, which first fetches the popped entry, then the new newest entry.
// Stall: a new request is taken only when the output register is empty or
//   is being taken in the same cycle; the result word holds until taken.
// Reset: pointers and counts cleared, max_drift returns to 100, the output
//   register is emptied; ram contents are not cleared.
module paired_sensor_ring_buffer_unit #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  psrb_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output psrb_pkg::rsp_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psrb_pkg::STAMP_BITS-1:0] cfg_data
);

  localparam int ENTRY_BITS = psrb_pkg::STAMP_BITS + PAYLOAD_BITS;
  localparam int AB = psrb_pkg::ADDR_BITS;
  localparam int FB = psrb_pkg::FILL_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP1 = 2'd1;
  localparam logic [1:0] S_POP2 = 2'd2;

  logic [1:0]                      state;
  logic [AB-1:0]                   radar_wr_ptr, cam_wr_ptr;
  logic [FB-1:0]                   radar_count, cam_count;
  logic [psrb_pkg::STAMP_BITS-1:0] max_drift;
  logic [psrb_pkg::STAMP_BITS-1:0] radar_top, cam_top;
  logic [ENTRY_BITS-1:0]           radar_pop, cam_pop;

  logic                  accept;
  logic                  radar_we, cam_we;
  logic [ENTRY_BITS-1:0] wr_entry;
  logic [ENTRY_BITS-1:0] radar_rd, cam_rd;
  logic [FB-1:0]         radar_count_inc, cam_count_inc;
  logic                  pop_ok;

  logic [psrb_pkg::STAMP_BITS-1:0] chk_radar, chk_cam;
  logic [FB-1:0]                   chk_radar_cnt, chk_cam_cnt;
  logic                            sync_flag;
  psrb_pkg::rsp_t                  rsp_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign pop_ok    = (radar_count != '0) && (cam_count != '0);

  // write side of both rams
  assign radar_we = accept && (in_data.req_type == psrb_pkg::REQ_PUSH_RADAR);
  assign cam_we   = accept && (in_data.req_type == psrb_pkg::REQ_PUSH_CAM);
  assign wr_entry = {in_data.stamp, in_data.payload[PAYLOAD_BITS-1:0]};

  // saturating counts for a push
  assign radar_count_inc = (radar_count < FB'(psrb_pkg::DEPTH)) ? radar_count + FB'(1)
                                                                 : radar_count;
  assign cam_count_inc   = (cam_count < FB'(psrb_pkg::DEPTH)) ? cam_count + FB'(1)
                                                               : cam_count;

  // read address is always the newest entry; reads the popped entry in the
  // accept cycle and the new newest entry once the pointer has stepped back
  psrb_ram #(.WIDTH(ENTRY_BITS), .DEPTH(psrb_pkg::DEPTH)) u_radar_ram (
    .clk     (clk),
    .wr_en   (radar_we),
    .wr_addr (radar_wr_ptr),
    .wr_data (wr_entry),
    .rd_addr (psrb_pkg::ptr_prev(radar_wr_ptr)),
    .rd_data (radar_rd)
  );

  psrb_ram #(.WIDTH(ENTRY_BITS), .DEPTH(psrb_pkg::DEPTH)) u_cam_ram (
    .clk     (clk),
    .wr_en   (cam_we),
    .wr_addr (cam_wr_ptr),
    .wr_data (wr_entry),
    .rd_addr (psrb_pkg::ptr_prev(cam_wr_ptr)),
    .rd_data (cam_rd)
  );

  // newest stamps and fills after this step, for the drift check
  always_comb begin
    chk_radar     = radar_top;
    chk_cam       = cam_top;
    chk_radar_cnt = radar_count;
    chk_cam_cnt   = cam_count;
    if (state == S_POP2) begin
      chk_radar = radar_rd[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
      chk_cam   = cam_rd[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
    end else if (in_data.req_type == psrb_pkg::REQ_PUSH_RADAR) begin
      chk_radar     = in_data.stamp;
      chk_radar_cnt = radar_count_inc;
    end else if (in_data.req_type == psrb_pkg::REQ_PUSH_CAM) begin
      chk_cam     = in_data.stamp;
      chk_cam_cnt = cam_count_inc;
    end
  end

  psrb_sync u_sync (
    .radar_stamp (chk_radar),
    .cam_stamp   (chk_cam),
    .max_drift   (max_drift),
    .radar_held  (chk_radar_cnt != '0),
    .cam_held    (chk_cam_cnt != '0),
    .in_sync     (sync_flag)
  );

  // result word
  always_comb begin
    rsp_next             = '0;
    rsp_next.in_sync     = sync_flag;
    rsp_next.radar_fill  = chk_radar_cnt;
    rsp_next.cam_fill    = chk_cam_cnt;
    if (state == S_POP2) begin
      rsp_next.radar_stamp = radar_pop[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
      rsp_next.radar_data  = psrb_pkg::DATA_BITS'(radar_pop[PAYLOAD_BITS-1:0]);
      rsp_next.cam_stamp   = cam_pop[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
      rsp_next.cam_data    = psrb_pkg::DATA_BITS'(cam_pop[PAYLOAD_BITS-1:0]);
    end else if (in_data.req_type == psrb_pkg::REQ_POP) begin
      rsp_next.empty_error = 1'b1;
    end
  end

  // control: sequencer, pointers, counts, drift register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      radar_wr_ptr <= '0;
      cam_wr_ptr   <= '0;
      radar_count  <= '0;
      cam_count    <= '0;
      out_valid    <= 1'b0;
      max_drift    <= psrb_pkg::STAMP_BITS'(100);
    end else begin
      if (cfg_valid) begin
        max_drift <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.req_type)
              psrb_pkg::REQ_PUSH_RADAR: begin
                radar_wr_ptr <= psrb_pkg::ptr_next(radar_wr_ptr);
                radar_count  <= radar_count_inc;
                out_valid    <= 1'b1;
              end
              psrb_pkg::REQ_PUSH_CAM: begin
                cam_wr_ptr <= psrb_pkg::ptr_next(cam_wr_ptr);
                cam_count  <= cam_count_inc;
                out_valid  <= 1'b1;
              end
              psrb_pkg::REQ_POP: begin
                if (pop_ok) begin
                  radar_wr_ptr <= psrb_pkg::ptr_prev(radar_wr_ptr);
                  cam_wr_ptr   <= psrb_pkg::ptr_prev(cam_wr_ptr);
                  radar_count  <= radar_count - FB'(1);
                  cam_count    <= cam_count - FB'(1);
                  state        <= S_POP1;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              psrb_pkg::REQ_NOP: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_POP1: state <= S_POP2;
        S_POP2: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers: result word, popped entries, newest stamp cache
  always_ff @(posedge clk) begin
    if (state == S_POP1) begin
      radar_pop <= radar_rd;
      cam_pop   <= cam_rd;
    end
    if (state == S_POP2) begin
      out_data  <= rsp_next;
      radar_top <= radar_rd[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
      cam_top   <= cam_rd[ENTRY_BITS-1 -: psrb_pkg::STAMP_BITS];
    end else if (accept) begin
      if (in_data.req_type != psrb_pkg::REQ_POP || !pop_ok) begin
        out_data <= rsp_next;
      end
      if (in_data.req_type == psrb_pkg::REQ_PUSH_RADAR) begin
        radar_top <= in_data.stamp;
      end
      if (in_data.req_type == psrb_pkg::REQ_PUSH_CAM) begin
        cam_top <= in_data.stamp;
      end
    end
  end

  // fills never go past the ring depth
  assert property (@(posedge clk) disable iff (rst)
    (radar_count <= FB'(psrb_pkg::DEPTH)) && (cam_count <= FB'(psrb_pkg::DEPTH)))
    else $error("fill count beyond ring depth");

  // an accepted request yields a result word next cycle or enters the pop sequence
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || state == S_POP1))
    else $error("accepted request produced neither result nor pop sequence");

  // a refused pop carries no sample
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_error) |->
      (out_data.radar_stamp == '0 && out_data.cam_stamp == '0 &&
       out_data.radar_data == '0 && out_data.cam_data == '0))
    else $error("refused pop carries sample data");

  // sync is only reported with both rings holding samples
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.in_sync) |->
      (out_data.radar_fill != '0 && out_data.cam_fill != '0))
    else $error("sync reported with an empty ring");

endmodule

/* hw/rtl/psrb_ram.sv */
// psrb_ram: generic simple dual port ram, one write port, one registered read
// no package dependencies
module psrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/psrb_sync.sv */
// psrb_sync: timestamp drift check between newest radar and camera samples
// depends on psrb_pkg
module psrb_sync (
  input  logic [psrb_pkg::STAMP_BITS-1:0] radar_stamp,
  input  logic [psrb_pkg::STAMP_BITS-1:0] cam_stamp,
  input  logic [psrb_pkg::STAMP_BITS-1:0] max_drift,
  input  logic                            radar_held,
  input  logic                            cam_held,
  output logic                            in_sync
);

  logic [psrb_pkg::STAMP_BITS-1:0] diff;

  // absolute difference, then strict compare against the drift limit
  always_comb begin
    diff    = (cam_stamp >= radar_stamp) ? cam_stamp - radar_stamp : radar_stamp - cam_stamp;
    in_sync = radar_held && cam_held && (diff < max_drift);
  end

endmodule

/* verif/tb_paired_sensor_ring_buffer_unit.sv */
// tb_paired_sensor_ring_buffer_unit: self-checking testbench for the paired sensor
// ring buffer, with directed and random request words under idle and stall phases
// depends on psrb_pkg and paired_sensor_ring_buffer_unit
module tb_paired_sensor_ring_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import psrb_pkg::*;

  localparam int PAYLOAD_W       = 32;
  localparam int RADAR           = 0;
  localparam int CAM             = 1;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int RANDOM_PHASES   = 8;
  localparam int CYCLE_LIMIT     = 200000;

  // predicts the result word of every accepted request and checks the dut words
  class pair_result_board;
    logic [STAMP_BITS-1:0] stamps [2][DEPTH];
    logic [DATA_BITS-1:0]  words  [2][DEPTH];
    int                    head   [2];
    int                    held   [2];
    logic [STAMP_BITS-1:0] drift;
    rsp_t                  expected_results [$];
    int                    mismatches;
    int                    results_seen;

    function new();
      head[RADAR]  = 0;
      head[CAM]    = 0;
      held[RADAR]  = 0;
      held[CAM]    = 0;
      drift        = 32'd100;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // newest stamps of both stores closer than the drift limit
    function logic pair_in_sync();
      logic [STAMP_BITS-1:0] rs, cs, gap;
      if (held[RADAR] == 0 || held[CAM] == 0) return 1'b0;
      rs  = stamps[RADAR][(head[RADAR] + DEPTH - 1) % DEPTH];
      cs  = stamps[CAM][(head[CAM] + DEPTH - 1) % DEPTH];
      gap = (cs >= rs) ? cs - rs : rs - cs;
      return gap < drift;
    endfunction

    // apply one accepted request word and queue its result
    function void note_request(req_t r);
      rsp_t e;
      int   s;
      e = '0;
      case (r.req_type)
        REQ_PUSH_RADAR, REQ_PUSH_CAM: begin
          s = (r.req_type == REQ_PUSH_RADAR) ? RADAR : CAM;
          stamps[s][head[s]] = r.stamp;
          words[s][head[s]]  = r.payload & DATA_BITS'((64'd1 << PAYLOAD_W) - 1);
          head[s] = (head[s] + 1) % DEPTH;
          if (held[s] < DEPTH) held[s]++;
        end
        REQ_POP: begin
          if (held[RADAR] == 0 || held[CAM] == 0) begin
            e.empty_error = 1'b1;
          end else begin
            for (int k = 0; k < 2; k++) begin
              head[k] = (head[k] + DEPTH - 1) % DEPTH;
              held[k]--;
            end
            e.radar_stamp = stamps[RADAR][head[RADAR]];
            e.radar_data  = words[RADAR][head[RADAR]];
            e.cam_stamp   = stamps[CAM][head[CAM]];
            e.cam_data    = words[CAM][head[CAM]];
          end
        end
        default: begin
        end
      endcase
      e.in_sync    = pair_in_sync();
      e.radar_fill = FILL_BITS'(held[RADAR]);
      e.cam_fill   = FILL_BITS'(held[CAM]);
      expected_results.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // compare one result word with the oldest prediction
    task check_result(rsp_t got);
      rsp_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      e = expected_results.pop_front();
      compare_field("empty_error", 32'(got.empty_error), 32'(e.empty_error));
      compare_field("radar_stamp", got.radar_stamp, e.radar_stamp);
      compare_field("radar_data", got.radar_data, e.radar_data);
      compare_field("cam_stamp", got.cam_stamp, e.cam_stamp);
      compare_field("cam_data", got.cam_data, e.cam_data);
      compare_field("in_sync", 32'(got.in_sync), 32'(e.in_sync));
      compare_field("radar_fill", 32'(got.radar_fill), 32'(e.radar_fill));
      compare_field("cam_fill", 32'(got.cam_fill), 32'(e.cam_fill));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  req_t                  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [STAMP_BITS-1:0] cfg_data = '0;

  pair_result_board      board;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_count = 0;
  logic [STAMP_BITS-1:0] stamp_base;

  paired_sensor_ring_buffer_unit #(
    .PAYLOAD_BITS(PAYLOAD_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // take result words at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [31:0] stamp, logic [31:0] payload);
    req_t r;
    r.req_type = op;
    r.stamp    = stamp;
    r.payload  = payload;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  // sender holds off until every predicted word has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_drift(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.drift = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random request: stamps mostly near a slowly moving base so sync goes both ways
  function automatic req_t random_request(input int burst);
    int          radar_cut [3] = '{36, 45, 16};
    int          cam_cut   [3] = '{72, 90, 32};
    int          pick;
    logic [1:0]  op;
    logic [31:0] stamp;
    pick = $urandom_range(99);
    if (pick < radar_cut[burst])      op = REQ_PUSH_RADAR;
    else if (pick < cam_cut[burst])   op = REQ_PUSH_CAM;
    else if (pick < 98)               op = REQ_POP;
    else                              op = REQ_NOP;
    pick = $urandom_range(99);
    if (pick < 3)       stamp = 32'h0;
    else if (pick < 6)  stamp = 32'hFFFF_FFFF;
    else if (pick < 70) stamp = stamp_base + $urandom_range(0, 300);
    else if (pick < 88) stamp = stamp_base + $urandom_range(0, 1 << 20);
    else                stamp = $urandom;
    stamp_base = stamp_base + $urandom_range(0, 40);
    return make_req(op, stamp, $urandom);
  endfunction

  initial begin
    logic [31:0] phase_drift [7] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd300, 32'd5000,
                                     32'd100, 32'd64};
    int          phase_idle  [4] = '{0, 49, 0, 15};
    int          phase_stall [4] = '{0, 0, 49, 15};
    req_t        r;
    int          counted;
    int          burst;

    board      = new();
    stamp_base = $urandom;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: refused pops, no-op, sync edges, stamp and payload extremes
    write_max_drift(32'd100);
    send_request(make_req(REQ_POP, 32'h0, 32'h0));
    send_request(make_req(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(REQ_PUSH_RADAR, 32'h0, 32'h0));
    send_request(make_req(REQ_POP, 32'h0, 32'h0));
    send_request(make_req(REQ_PUSH_CAM, 32'd99, 32'hFFFF_FFFF));
    send_request(make_req(REQ_PUSH_CAM, 32'd100, 32'h0));
    send_request(make_req(REQ_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(REQ_PUSH_RADAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_req(REQ_PUSH_CAM, 32'hFFFF_FFFF, 32'h5A5A_A5A5));
    // radar store wraps and overwrites its oldest word
    for (int i = 0; i < DEPTH; i++) begin
      send_request(make_req(REQ_PUSH_RADAR,
                            (i % 2 == 0) ? 32'hAAAA_AAAA + i : 32'h5555_5555 + i,
                            (i % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA));
    end
    send_request(make_req(REQ_POP, 32'h0, 32'h0));
    send_request(make_req(REQ_POP, 32'h0, 32'h0));
    wait_results_done();

    // random phases, each with its own drift limit and one of four idle and stall patterns
    burst = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct  = phase_idle[p % 4];
      stall_pct = phase_stall[p % 4];
      write_max_drift((p < 7) ? phase_drift[p] : $urandom);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(59) == 0) wait_results_done();
        if ($urandom_range(11) == 0) burst = $urandom_range(2);
        r = random_request(burst);
        send_request(r);
        if (r.req_type != REQ_NOP) counted++;
      end
      wait_results_done();
    end

    stall_pct = 0;
    repeat (20) @(negedge clk);
    if (board.mismatches == 0 && board.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
